@@ rtl/core/bfds_pkg.sv @@
// Package for the back-to-front depth sorter.
// Holds widths, register indexes, state codes and the structs shared by all rtl/core files.
// Depends on nothing.
package bfds_pkg;

  localparam int unsigned ID_W          = 64;
  localparam int unsigned IDX_W         = 10;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned DEF_MAX_ENTRIES = 64;
  localparam int unsigned DEF_MAX_PIECES  = 1024;
  localparam int unsigned DEF_COORD_BITS  = 21;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAMERA_X = 2'd0,
    REG_CAMERA_Y = 2'd1,
    REG_CAMERA_Z = 2'd2
  } reg_idx_e;

  typedef enum logic {
    ST_FILL  = 1'b0,
    ST_DRAIN = 1'b1
  } state_e;

  // Tag that travels alongside an item through the distance pipeline.
  typedef struct packed {
    logic valid;
    logic transp;
    logic last;
  } tag_t;

  // Command broadcast to every cell of the sort chain.
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

endpackage

@@ rtl/core/bfds_dist.sv @@
// Three-stage squared-distance pipeline: difference magnitudes, squares, sum.
// Depends on bfds_pkg for the item tag struct and field widths.
module bfds_dist #(
  parameter int unsigned COORD_BITS = bfds_pkg::DEF_COORD_BITS,
  parameter int unsigned DIST_W     = 2 * COORD_BITS + 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bfds_pkg::tag_t                tag_i,
  input  logic signed [COORD_BITS-1:0]  pos_x_i,
  input  logic signed [COORD_BITS-1:0]  pos_y_i,
  input  logic signed [COORD_BITS-1:0]  pos_z_i,
  input  logic signed [COORD_BITS-1:0]  cam_x_i,
  input  logic signed [COORD_BITS-1:0]  cam_y_i,
  input  logic signed [COORD_BITS-1:0]  cam_z_i,
  input  logic [bfds_pkg::ID_W-1:0]     id_i,
  input  logic [bfds_pkg::IDX_W-1:0]    idx_i,
  output bfds_pkg::tag_t                tag_o,
  output logic [DIST_W-1:0]             dist_o,
  output logic [bfds_pkg::ID_W-1:0]     id_o,
  output logic [bfds_pkg::IDX_W-1:0]    idx_o,
  output logic                          last_busy_o
);

  localparam int unsigned DIFF_W = COORD_BITS + 1;

  logic signed [COORD_BITS-1:0] pos [3];
  logic signed [COORD_BITS-1:0] cam [3];
  logic signed [DIFF_W-1:0]     diff [3];
  logic [DIFF_W-1:0]            mag_d [3];
  logic [DIFF_W-1:0]            mag_q [3];
  logic [DIST_W-1:0]            sq_q [3];
  logic [DIST_W-1:0]            dist_q;

  bfds_pkg::tag_t               tag1_q, tag2_q, tag3_q;
  logic [bfds_pkg::ID_W-1:0]    id1_q, id2_q, id3_q;
  logic [bfds_pkg::IDX_W-1:0]   idx1_q, idx2_q, idx3_q;

  assign pos[0] = pos_x_i;
  assign pos[1] = pos_y_i;
  assign pos[2] = pos_z_i;
  assign cam[0] = cam_x_i;
  assign cam[1] = cam_y_i;
  assign cam[2] = cam_z_i;

  for (genvar k = 0; k < 3; k++) begin : g_axis
    // One extra bit keeps the difference exact for any pair of coordinates.
    assign diff[k]  = DIFF_W'(pos[k]) - DIFF_W'(cam[k]);
    assign mag_d[k] = diff[k][DIFF_W-1] ? DIFF_W'(-diff[k]) : DIFF_W'(diff[k]);

    always_ff @(posedge clk_i) begin
      mag_q[k] <= mag_d[k];
      sq_q[k]  <= DIST_W'(mag_q[k]) * DIST_W'(mag_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q <= sq_q[0] + sq_q[1] + sq_q[2];
    id1_q  <= id_i;
    id2_q  <= id1_q;
    id3_q  <= id2_q;
    idx1_q <= idx_i;
    idx2_q <= idx1_q;
    idx3_q <= idx2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      tag3_q <= '0;
    end else begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;
    end
  end

  assign tag_o  = tag3_q;
  assign dist_o = dist_q;
  assign id_o   = id3_q;
  assign idx_o  = idx3_q;

  assign last_busy_o = (tag1_q.valid && tag1_q.last) || (tag2_q.valid && tag2_q.last)
                    || (tag3_q.valid && tag3_q.last);

endmodule

@@ rtl/core/bfds_cell.sv @@
// One cell of the sort chain: holds one entry and compares it with the item being inserted.
// Depends on bfds_pkg for the cell command struct and field widths.
module bfds_cell #(
  parameter int unsigned DIST_W = 2 * bfds_pkg::DEF_COORD_BITS + 2
) (
  input  logic                         clk_i,
  input  bfds_pkg::cell_ctrl_t         ctrl_i,
  input  logic                         occupied_i,
  input  logic                         prev_ahead_i,
  input  logic [DIST_W-1:0]            prev_dist_i,
  input  logic [bfds_pkg::ID_W-1:0]    prev_id_i,
  input  logic [bfds_pkg::IDX_W-1:0]   prev_idx_i,
  input  logic [DIST_W-1:0]            next_dist_i,
  input  logic [bfds_pkg::ID_W-1:0]    next_id_i,
  input  logic [bfds_pkg::IDX_W-1:0]   next_idx_i,
  input  logic [DIST_W-1:0]            new_dist_i,
  input  logic [bfds_pkg::ID_W-1:0]    new_id_i,
  input  logic [bfds_pkg::IDX_W-1:0]   new_idx_i,
  output logic                         ahead_o,
  output logic [DIST_W-1:0]            dist_o,
  output logic [bfds_pkg::ID_W-1:0]    id_o,
  output logic [bfds_pkg::IDX_W-1:0]   idx_o
);

  logic [DIST_W-1:0]          dist_q;
  logic [bfds_pkg::ID_W-1:0]  id_q;
  logic [bfds_pkg::IDX_W-1:0] idx_q;

  // A stored entry stays ahead when it is farther away, or equally far with an id
  // no larger than the new one, so equal keys keep their arrival order.
  assign ahead_o = occupied_i &&
                   ((dist_q != new_dist_i) ? (dist_q > new_dist_i) : (id_q <= new_id_i));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.insert && !ahead_o) begin
      if (prev_ahead_i) begin
        dist_q <= new_dist_i;
        id_q   <= new_id_i;
        idx_q  <= new_idx_i;
      end else begin
        dist_q <= prev_dist_i;
        id_q   <= prev_id_i;
        idx_q  <= prev_idx_i;
      end
    end else if (ctrl_i.shift) begin
      dist_q <= next_dist_i;
      id_q   <= next_id_i;
      idx_q  <= next_idx_i;
    end
  end

  assign dist_o = dist_q;
  assign id_o   = id_q;
  assign idx_o  = idx_q;

endmodule

@@ rtl/core/back_to_front_depth_sort.sv @@
// Back-to-front depth sorter. While a frame fills, one item is taken per cycle unless the input
// is stalled: its squared distance to the camera comes out of a three-stage pipeline and is
// inserted into a chain of MAX_ENTRIES cells kept farthest first. After the item marked last,
// the input is held while that item is in the pipeline and while the frame drains; the sorted
// indices leave at one result per cycle while out_stall_i is low (N results, or one empty
// result when no transparent item came). Further transparent items beyond capacity are
// dropped and every result of that frame carries the overflow flag.
module back_to_front_depth_sort #(
  parameter int unsigned MAX_ENTRIES = bfds_pkg::DEF_MAX_ENTRIES,
  parameter int unsigned MAX_PIECES  = bfds_pkg::DEF_MAX_PIECES,
  parameter int unsigned COORD_BITS  = bfds_pkg::DEF_COORD_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bfds_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [COORD_BITS-1:0]             cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [COORD_BITS-1:0]      piece_x_i,
  input  logic signed [COORD_BITS-1:0]      piece_y_i,
  input  logic signed [COORD_BITS-1:0]      piece_z_i,
  input  logic [bfds_pkg::ID_W-1:0]         piece_id_i,
  input  logic                              is_transparent_i,
  input  logic                              last_piece_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [bfds_pkg::IDX_W-1:0]        piece_index_o,
  output logic                              last_result_o,
  output logic                              empty_res_o,
  output logic                              overflow_o
);

  localparam int unsigned DIST_W = 2 * COORD_BITS + 2;
  localparam int unsigned CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned PCNT_W = $clog2(MAX_PIECES);

  logic signed [COORD_BITS-1:0] cam_x_q, cam_y_q, cam_z_q;

  logic                         in_accept;
  bfds_pkg::tag_t               in_tag;
  logic [PCNT_W-1:0]            pcnt_q, pcnt_d;

  bfds_pkg::tag_t               tail_tag;
  logic [DIST_W-1:0]            tail_dist;
  logic [bfds_pkg::ID_W-1:0]    tail_id;
  logic [bfds_pkg::IDX_W-1:0]   tail_idx;
  logic                         last_busy;

  bfds_pkg::state_e             state_q, state_d;
  logic [CNT_W-1:0]             count_q, count_d;
  logic                         dropped_q, dropped_d;
  bfds_pkg::cell_ctrl_t         cell_ctrl;

  logic                         out_valid_q, out_valid_d;
  logic [bfds_pkg::IDX_W-1:0]   out_idx_q, out_idx_d;
  logic                         out_last_q, out_last_d;
  logic                         out_empty_q, out_empty_d;
  logic                         out_ovf_q, out_ovf_d;
  logic                         out_load;

  logic [MAX_ENTRIES-1:0]       ahead;
  logic [DIST_W-1:0]            c_dist [MAX_ENTRIES];
  logic [bfds_pkg::ID_W-1:0]    c_id   [MAX_ENTRIES];
  logic [bfds_pkg::IDX_W-1:0]   c_idx  [MAX_ENTRIES];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q <= '0;
      cam_y_q <= '0;
      cam_z_q <= '0;
    end else if (cfg_we_i) begin
      case (bfds_pkg::reg_idx_e'(cfg_idx_i))
        bfds_pkg::REG_CAMERA_X: cam_x_q <= cfg_wdata_i;
        bfds_pkg::REG_CAMERA_Y: cam_y_q <= cfg_wdata_i;
        bfds_pkg::REG_CAMERA_Z: cam_z_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input side: running piece index, restarted after the last item of a frame or after MAX_PIECES - 1.
  assign in_stall_o = (state_q == bfds_pkg::ST_DRAIN) || last_busy;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign in_tag.valid  = in_accept;
  assign in_tag.transp = is_transparent_i;
  assign in_tag.last   = last_piece_i;

  always_comb begin
    pcnt_d = pcnt_q;
    if (in_accept) begin
      if (last_piece_i || (pcnt_q == PCNT_W'(MAX_PIECES - 1))) begin
        pcnt_d = '0;
      end else begin
        pcnt_d = pcnt_q + PCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcnt_q <= '0;
    end else begin
      pcnt_q <= pcnt_d;
    end
  end

  bfds_dist #(
    .COORD_BITS (COORD_BITS),
    .DIST_W     (DIST_W)
  ) u_dist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tag_i       (in_tag),
    .pos_x_i     (piece_x_i),
    .pos_y_i     (piece_y_i),
    .pos_z_i     (piece_z_i),
    .cam_x_i     (cam_x_q),
    .cam_y_i     (cam_y_q),
    .cam_z_i     (cam_z_q),
    .id_i        (piece_id_i),
    .idx_i       (bfds_pkg::IDX_W'(pcnt_q)),
    .tag_o       (tail_tag),
    .dist_o      (tail_dist),
    .id_o        (tail_id),
    .idx_o       (tail_idx),
    .last_busy_o (last_busy)
  );

  // Sort chain. Cell i is occupied while i is below the entry count.
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic                       prev_ahead;
    logic [DIST_W-1:0]          prev_dist, next_dist;
    logic [bfds_pkg::ID_W-1:0]  prev_id, next_id;
    logic [bfds_pkg::IDX_W-1:0] prev_idx, next_idx;

    if (i == 0) begin : g_head
      assign prev_ahead = 1'b1;
      assign prev_dist  = '0;
      assign prev_id    = '0;
      assign prev_idx   = '0;
    end else begin : g_body
      assign prev_ahead = ahead[i-1];
      assign prev_dist  = c_dist[i-1];
      assign prev_id    = c_id[i-1];
      assign prev_idx   = c_idx[i-1];
    end

    if (i == MAX_ENTRIES - 1) begin : g_tail
      assign next_dist = '0;
      assign next_id   = '0;
      assign next_idx  = '0;
    end else begin : g_link
      assign next_dist = c_dist[i+1];
      assign next_id   = c_id[i+1];
      assign next_idx  = c_idx[i+1];
    end

    bfds_cell #(
      .DIST_W (DIST_W)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (cell_ctrl),
      .occupied_i   (count_q > CNT_W'(i)),
      .prev_ahead_i (prev_ahead),
      .prev_dist_i  (prev_dist),
      .prev_id_i    (prev_id),
      .prev_idx_i   (prev_idx),
      .next_dist_i  (next_dist),
      .next_id_i    (next_id),
      .next_idx_i   (next_idx),
      .new_dist_i   (tail_dist),
      .new_id_i     (tail_id),
      .new_idx_i    (tail_idx),
      .ahead_o      (ahead[i]),
      .dist_o       (c_dist[i]),
      .id_o         (c_id[i]),
      .idx_o        (c_idx[i])
    );
  end

  // Frame control and output register.
  assign out_load = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d          = state_q;
    count_d          = count_q;
    dropped_d        = dropped_q;
    cell_ctrl.insert = 1'b0;
    cell_ctrl.shift  = 1'b0;
    out_valid_d      = out_valid_q && out_stall_i;
    out_idx_d        = out_idx_q;
    out_last_d       = out_last_q;
    out_empty_d      = out_empty_q;
    out_ovf_d        = out_ovf_q;

    case (state_q)
      bfds_pkg::ST_FILL: begin
        if (tail_tag.valid) begin
          if (tail_tag.transp) begin
            if (count_q == CNT_W'(MAX_ENTRIES)) begin
              dropped_d = 1'b1;
            end else begin
              cell_ctrl.insert = 1'b1;
              count_d          = count_q + CNT_W'(1);
            end
          end
          if (tail_tag.last) begin
            state_d = bfds_pkg::ST_DRAIN;
          end
        end
      end
      bfds_pkg::ST_DRAIN: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          out_ovf_d   = dropped_q;
          if (count_q == '0) begin
            out_idx_d   = '0;
            out_last_d  = 1'b1;
            out_empty_d = 1'b1;
            state_d     = bfds_pkg::ST_FILL;
            dropped_d   = 1'b0;
          end else begin
            out_idx_d       = c_idx[0];
            out_last_d      = (count_q == CNT_W'(1));
            out_empty_d     = 1'b0;
            cell_ctrl.shift = 1'b1;
            count_d         = count_q - CNT_W'(1);
            if (count_q == CNT_W'(1)) begin
              state_d   = bfds_pkg::ST_FILL;
              dropped_d = 1'b0;
            end
          end
        end
      end
      default: begin
        state_d = bfds_pkg::ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bfds_pkg::ST_FILL;
      count_q     <= '0;
      dropped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      dropped_q   <= dropped_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_idx_q   <= out_idx_d;
    out_last_q  <= out_last_d;
    out_empty_q <= out_empty_d;
    out_ovf_q   <= out_ovf_d;
  end

  assign out_valid_o   = out_valid_q;
  assign piece_index_o = out_idx_q;
  assign last_result_o = out_last_q;
  assign empty_res_o   = out_empty_q;
  assign overflow_o    = out_ovf_q;

endmodule

@@ rtl/core/bfds_chk.sv @@
// Port-level checker for the back-to-front depth sorter, bound to the top level.
// Depends on bfds_pkg and back_to_front_depth_sort.
module bfds_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              last_piece_i,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [bfds_pkg::IDX_W-1:0]        piece_index_o,
  input logic                              last_result_o,
  input logic                              empty_res_o,
  input logic                              overflow_o
);

  // A stalled result holds still.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(piece_index_o)
      && $stable(last_result_o) && $stable(empty_res_o) && $stable(overflow_o))
    else $error("stalled result changed");

  // The empty result is always the only and final one, with a zero index.
  a_empty_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && empty_res_o |-> last_result_o && (piece_index_o == '0))
    else $error("malformed empty result");

  // Once a frame closes, no further item is taken until it has drained.
  a_close_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_piece_i |=> in_stall_o)
    else $error("input taken while a frame closes");

  // Within a frame the results follow each other without gaps and share the overflow flag.
  a_frame_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_result_o |=>
      out_valid_o && !empty_res_o && (overflow_o == $past(overflow_o)))
    else $error("broken result run");

endmodule

bind back_to_front_depth_sort bfds_chk u_bfds_chk (.*);
